// File: hdl/assert_macros.svh
// Assertion macros used by the checker file dff_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DFF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DFF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/dff_pkg.sv
// Package for the Dixon factor finder: widths, factor base, status codes, states.
// No dependencies.
`default_nettype none

package dff_pkg;

	localparam int NUM_W = 16;
	localparam int NPRIMES = 4;
	localparam int MAX_REL = NPRIMES + 1;
	localparam int REL_W = $clog2(MAX_REL + 1);
	localparam int MASK_W = MAX_REL + 1;
	localparam int OMASK_W = MAX_REL;
	localparam int EXP_W = $clog2(NUM_W);
	localparam int SUM_W = $clog2(MAX_REL * (NUM_W - 1) + 1);
	localparam int J_W = $clog2(NPRIMES);
	localparam int CNT_W = $clog2(NUM_W);
	localparam int ROOT_W = NUM_W / 2 + 1;
	localparam int ST_W = 2;

	// primes up to the factor base limit of 7
	localparam logic [NUM_W-1:0] PRIMES [NPRIMES] = '{
		NUM_W'(2), NUM_W'(3), NUM_W'(5), NUM_W'(7)
	};

	localparam logic [ST_W-1:0] ST_FACTOR  = 2'd0;
	localparam logic [ST_W-1:0] ST_TRIVIAL = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE    = 2'd2;

	typedef logic [EXP_W-1:0] exp_t;
	typedef exp_t [NPRIMES-1:0] exp_vec_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQRT,
		S_SCHK,
		S_MUL,
		S_SQ_RET,
		S_TRIAL,
		S_DIV,
		S_TRIAL_RET,
		S_SMOOTH,
		S_NEXT,
		S_SUB_TEST,
		S_SUB_ACC,
		S_SUB_EVAL,
		S_XP,
		S_XP_RET,
		S_YP,
		S_YP_RET,
		S_GCD_INIT,
		S_GCD_TWO,
		S_GCD_RUN,
		S_COF_RET,
		S_DONE
	} dff_state_t;

endpackage

`default_nettype wire

// File: hdl/dixon_factor_finder_core.sv
// Dixon factor finder: sequencer with bit-serial modular multiplier, divider and gcd.
// Depends on dff_pkg.
`default_nettype none

// One number is taken at a time; in_ready is high only while the core is idle, and a
// finished result waits in the output register while the next number is taken, but a
// later result holds the core in S_DONE until that register is free. Steps per number:
// the ceiling root by an incremental square search, then per candidate the bit-serial
// squaring mod n and a trial division by 2, 3, 5, 7 for each prime and for each prime
// factor removed, for at most n candidates; then the subset scan over up to 31 subsets,
// a modular product for each root and each half power, the binary gcd and a division
// for the cofactor. The 16-step shift-add multiplier and the 16-step restoring divider
// do the arithmetic.
module dixon_factor_finder_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [dff_pkg::NUM_W-1:0]           number,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [dff_pkg::ST_W-1:0]                 status,
	output logic [dff_pkg::NUM_W-1:0]                divisor,
	output logic [dff_pkg::NUM_W-1:0]                cofactor,
	output logic [dff_pkg::NUM_W-1:0]                x_product,
	output logic [dff_pkg::NUM_W-1:0]                y_product,
	output logic [dff_pkg::OMASK_W-1:0]              chosen_subset,
	output logic [dff_pkg::REL_W-1:0]                relations_found
);
	import dff_pkg::*;

	dff_state_t state_q, state_d, ret_q;
	logic out_valid_q;

	logic [NUM_W-1:0] n_q;
	logic [NUM_W:0] sq_q;
	logic [ROOT_W-1:0] rt_q;
	logic [NUM_W-1:0] xr_q, budget_q, res_q;
	logic [REL_W-1:0] rel_q, i_q;
	exp_vec_t ex_q;
	logic [J_W:0] pj_q;
	logic [MASK_W-1:0] mask_q;
	logic [SUM_W-1:0] sums_q [NPRIMES];
	logic [SUM_W-2:0] k_q;
	logic [NUM_W-1:0] xp_q, yp_q, ga_q, gb_q, dv_q, cf_q;
	logic [CNT_W-1:0] gk_q, cnt_q;
	logic [ST_W-1:0] st_q;

	logic [NUM_W-1:0] mm_a_q, mm_b_q, mm_acc_q;
	logic [NUM_W-1:0] div_q_q, div_r_q, div_d_q;

	logic [NUM_W-1:0] root_mem [MAX_REL];
	exp_vec_t exp_mem [MAX_REL];

	logic [NUM_W:0] n17, mm_t1, mm_t1r, mm_t2, mm_t3, dv_t, dv_new, xr_inc;
	logic dv_ge, cnt_last, sq_done, search_go, all_even, rem_zero, load_out;
	logic [MASK_W-1:0] mask_lim;
	logic [NUM_W-1:0] one_mod, gcd_res;

	assign n17 = {1'b0, n_q};
	assign mm_t1 = {mm_acc_q, 1'b0};
	assign mm_t1r = (mm_t1 >= n17) ? mm_t1 - n17 : mm_t1;
	assign mm_t2 = mm_b_q[NUM_W-1] ? mm_t1r + {1'b0, mm_a_q} : mm_t1r;
	assign mm_t3 = (mm_t2 >= n17) ? mm_t2 - n17 : mm_t2;

	assign dv_t = {div_r_q, div_q_q[NUM_W-1]};
	assign dv_ge = dv_t >= {1'b0, div_d_q};
	assign dv_new = dv_ge ? dv_t - {1'b0, div_d_q} : dv_t;

	assign cnt_last = cnt_q == CNT_W'(NUM_W - 1);
	assign sq_done = sq_q >= n17;
	assign search_go = (rel_q != REL_W'(MAX_REL)) && (budget_q != '0) && (n_q != '0);
	assign mask_lim = MASK_W'(1) << rel_q;
	assign rem_zero = div_r_q == '0;
	assign xr_inc = {1'b0, xr_q} + 1'b1;
	assign one_mod = (n_q == NUM_W'(1)) ? '0 : NUM_W'(1);
	assign gcd_res = gb_q << gk_q;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		all_even = 1'b1;
		for (int j = 0; j < NPRIMES; j++) begin
			if (sums_q[j][0]) begin
				all_even = 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_SQRT;
			S_SQRT: if (sq_done) state_d = S_SCHK;
			S_SCHK: state_d = search_go ? S_MUL : S_SUB_TEST;
			S_MUL: if (cnt_last) state_d = ret_q;
			S_DIV: if (cnt_last) state_d = ret_q;
			S_SQ_RET: state_d = (mm_acc_q == '0) ? S_NEXT : S_TRIAL;
			S_TRIAL: state_d = S_DIV;
			S_TRIAL_RET: begin
				if (rem_zero || pj_q != (J_W+1)'(NPRIMES - 1)) begin
					state_d = S_TRIAL;
				end else begin
					state_d = S_SMOOTH;
				end
			end
			S_SMOOTH: state_d = S_NEXT;
			S_NEXT: state_d = S_SCHK;
			S_SUB_TEST: state_d = (mask_q >= mask_lim) ? S_DONE : S_SUB_ACC;
			S_SUB_ACC: if (i_q == rel_q) state_d = S_SUB_EVAL;
			S_SUB_EVAL: state_d = all_even ? S_XP : S_SUB_TEST;
			S_XP: begin
				if (i_q == rel_q) begin
					state_d = S_YP;
				end else if (mask_q[i_q]) begin
					state_d = S_MUL;
				end
			end
			S_XP_RET: state_d = S_XP;
			S_YP: begin
				if (pj_q == (J_W+1)'(NPRIMES)) begin
					state_d = S_GCD_INIT;
				end else if (k_q != sums_q[pj_q[J_W-1:0]][SUM_W-1:1]) begin
					state_d = S_MUL;
				end
			end
			S_YP_RET: state_d = S_YP;
			S_GCD_INIT: state_d = S_GCD_TWO;
			S_GCD_TWO: if (ga_q == '0 || ga_q[0] || gb_q[0]) state_d = S_GCD_RUN;
			S_GCD_RUN: if (ga_q == '0) state_d = S_DIV;
			S_COF_RET: state_d = S_DONE;
			S_DONE: if (load_out) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == S_IDLE;
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q <= number;
				sq_q <= '0;
				rt_q <= '0;
			end
			S_SQRT: begin
				if (sq_done) begin
					xr_q <= (n_q == NUM_W'(rt_q)) ? '0 : NUM_W'(rt_q);
					budget_q <= n_q;
					rel_q <= '0;
					mask_q <= MASK_W'(1);
				end else begin
					sq_q <= sq_q + (NUM_W+1)'({rt_q, 1'b1});
					rt_q <= rt_q + 1'b1;
				end
			end
			S_SCHK: begin
				mm_a_q <= xr_q;
				mm_b_q <= xr_q;
				mm_acc_q <= '0;
				cnt_q <= '0;
				ret_q <= S_SQ_RET;
				budget_q <= budget_q - 1'b1;
			end
			S_MUL: begin
				mm_acc_q <= mm_t3[NUM_W-1:0];
				mm_b_q <= mm_b_q << 1;
				cnt_q <= cnt_q + 1'b1;
			end
			S_DIV: begin
				div_r_q <= dv_new[NUM_W-1:0];
				div_q_q <= {div_q_q[NUM_W-2:0], dv_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			S_SQ_RET: begin
				res_q <= mm_acc_q;
				ex_q <= '0;
				pj_q <= '0;
			end
			S_TRIAL: begin
				div_q_q <= res_q;
				div_r_q <= '0;
				div_d_q <= PRIMES[pj_q[J_W-1:0]];
				cnt_q <= '0;
				ret_q <= S_TRIAL_RET;
			end
			S_TRIAL_RET: begin
				if (rem_zero) begin
					res_q <= div_q_q;
					ex_q[pj_q[J_W-1:0]] <= ex_q[pj_q[J_W-1:0]] + 1'b1;
				end else begin
					pj_q <= pj_q + 1'b1;
				end
			end
			S_SMOOTH: begin
				if (res_q == NUM_W'(1)) begin
					root_mem[rel_q] <= xr_q;
					exp_mem[rel_q] <= ex_q;
					rel_q <= rel_q + 1'b1;
				end
			end
			S_NEXT: xr_q <= (xr_inc == n17) ? '0 : xr_inc[NUM_W-1:0];
			S_SUB_TEST: begin
				if (mask_q >= mask_lim) begin
					st_q <= ST_NONE;
					dv_q <= '0;
					cf_q <= '0;
					xp_q <= '0;
					yp_q <= '0;
					mask_q <= '0;
				end else begin
					for (int j = 0; j < NPRIMES; j++) sums_q[j] <= '0;
					i_q <= '0;
				end
			end
			S_SUB_ACC: begin
				if (i_q != rel_q) begin
					if (mask_q[i_q]) begin
						for (int j = 0; j < NPRIMES; j++) begin
							sums_q[j] <= sums_q[j] + SUM_W'(exp_mem[i_q][j]);
						end
					end
					i_q <= i_q + 1'b1;
				end
			end
			S_SUB_EVAL: begin
				if (all_even) begin
					xp_q <= one_mod;
					i_q <= '0;
				end else begin
					mask_q <= mask_q + 1'b1;
				end
			end
			S_XP: begin
				if (i_q == rel_q) begin
					yp_q <= one_mod;
					pj_q <= '0;
					k_q <= '0;
				end else if (mask_q[i_q]) begin
					mm_a_q <= xp_q;
					mm_b_q <= root_mem[i_q];
					mm_acc_q <= '0;
					cnt_q <= '0;
					ret_q <= S_XP_RET;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			S_XP_RET: begin
				xp_q <= mm_acc_q;
				i_q <= i_q + 1'b1;
			end
			S_YP: begin
				if (pj_q != (J_W+1)'(NPRIMES)) begin
					if (k_q == sums_q[pj_q[J_W-1:0]][SUM_W-1:1]) begin
						pj_q <= pj_q + 1'b1;
						k_q <= '0;
					end else begin
						mm_a_q <= yp_q;
						mm_b_q <= PRIMES[pj_q[J_W-1:0]];
						mm_acc_q <= '0;
						cnt_q <= '0;
						ret_q <= S_YP_RET;
					end
				end
			end
			S_YP_RET: begin
				yp_q <= mm_acc_q;
				k_q <= k_q + 1'b1;
			end
			S_GCD_INIT: begin
				ga_q <= (xp_q > yp_q) ? xp_q - yp_q : yp_q - xp_q;
				gb_q <= n_q;
				gk_q <= '0;
			end
			S_GCD_TWO: begin
				if (ga_q != '0 && !ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + 1'b1;
				end
			end
			S_GCD_RUN: begin
				if (ga_q == '0) begin
					dv_q <= gcd_res;
					div_q_q <= n_q;
					div_r_q <= '0;
					div_d_q <= gcd_res;
					cnt_q <= '0;
					ret_q <= S_COF_RET;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			S_COF_RET: begin
				cf_q <= div_q_q;
				st_q <= (dv_q != NUM_W'(1) && dv_q != n_q) ? ST_FACTOR : ST_TRIVIAL;
			end
			S_DONE: begin
				if (load_out) begin
					status <= st_q;
					divisor <= dv_q;
					cofactor <= cf_q;
					x_product <= xp_q;
					y_product <= yp_q;
					chosen_subset <= mask_q[OMASK_W-1:0];
					relations_found <= rel_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/dff_checker.sv
// Port-level checker for dixon_factor_finder_core, bound to dixon_factor_finder_core.
// Depends on dff_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dff_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic [dff_pkg::NUM_W-1:0]  number,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [dff_pkg::ST_W-1:0]   status,
	input wire logic [dff_pkg::NUM_W-1:0]  divisor,
	input wire logic [dff_pkg::NUM_W-1:0]  cofactor,
	input wire logic [dff_pkg::NUM_W-1:0]  x_product,
	input wire logic [dff_pkg::NUM_W-1:0]  y_product,
	input wire logic [dff_pkg::OMASK_W-1:0] chosen_subset,
	input wire logic [dff_pkg::REL_W-1:0]  relations_found
);
	import dff_pkg::*;

	`DFF_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")
	`DFF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(divisor) && $stable(status), "result dropped")
	`DFF_ASSERT_IMP(a_none_zero, clk, arst_n, out_valid && status == ST_NONE, divisor == '0 && cofactor == '0 && chosen_subset == '0, "nonzero fields without subset")
	`DFF_ASSERT_IMP(a_found_mask, clk, arst_n, out_valid && status != ST_NONE, chosen_subset != '0 && divisor != '0 && relations_found <= REL_W'(MAX_REL), "bad found result")

endmodule

bind dixon_factor_finder_core dff_checker u_dff_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for dixon_factor_finder_core: drives numbers, predicts each
// factoring attempt in a scoreboard class and compares every result field.
// Depends on dff_pkg and dixon_factor_finder_core.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dff_pkg::*;

	localparam int unsigned STALL_LIMIT = 100_000_000;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [NUM_W-1:0]   divisor;
		logic [NUM_W-1:0]   cofactor;
		logic [NUM_W-1:0]   x_product;
		logic [NUM_W-1:0]   y_product;
		logic [OMASK_W-1:0] chosen_subset;
		logic [REL_W-1:0]   relations_found;
	} factor_result_t;

	class factor_scoreboard;
		factor_result_t pending[$];
		int unsigned    errors;

		function automatic factor_result_t dixon_attempt(logic [NUM_W-1:0] num);
			longint unsigned n, root, budget, r, res, xp, yp, diff, a, b, t;
			longint unsigned roots [MAX_REL];
			int unsigned     exps [MAX_REL][NPRIMES];
			int unsigned     ex [NPRIMES];
			int unsigned     sums [NPRIMES];
			int unsigned     total, mask, i, j, k;
			bit              found, even;
			factor_result_t  o;
			n = num;
			root = 0;
			for (longint unsigned bt = 1 << 16; bt != 0; bt >>= 1)
				if ((root | bt) * (root | bt) <= n) root |= bt;
			if (root * root < n) root++;
			budget = n;
			total = 0;
			while (total < MAX_REL && budget > 0 && n != 0) begin
				r = root % n;
				res = (r * r) % n;
				budget--;
				if (res != 0) begin
					for (j = 0; j < NPRIMES; j++) begin
						ex[j] = 0;
						while (res % PRIMES[j] == 0) begin
							res /= PRIMES[j];
							ex[j]++;
						end
					end
					if (res == 1) begin
						roots[total] = root;
						exps[total] = ex;
						total++;
					end
				end
				root++;
			end
			found = 0;
			for (mask = 1; mask < (1 << total); mask++) begin
				even = 1;
				for (j = 0; j < NPRIMES; j++) sums[j] = 0;
				for (i = 0; i < total; i++)
					if (mask[i])
						for (j = 0; j < NPRIMES; j++) sums[j] += exps[i][j];
				for (j = 0; j < NPRIMES; j++)
					if (sums[j] % 2) even = 0;
				if (even) begin
					found = 1;
					break;
				end
			end
			o = '0;
			o.status = ST_NONE;
			o.relations_found = total;
			if (found) begin
				xp = 1 % n;
				yp = 1 % n;
				for (i = 0; i < total; i++)
					if (mask[i]) xp = (xp * (roots[i] % n)) % n;
				for (j = 0; j < NPRIMES; j++)
					for (k = 0; k < sums[j] / 2; k++) yp = (yp * (PRIMES[j] % n)) % n;
				diff = xp > yp ? xp - yp : yp - xp;
				a = diff;
				b = n;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				o.divisor = a;
				o.cofactor = a != 0 ? n / a : 0;
				o.x_product = xp;
				o.y_product = yp;
				o.chosen_subset = mask;
				o.status = (a != 1 && a != n) ? ST_FACTOR : ST_TRIVIAL;
			end
			return o;
		endfunction

		function void note_number(logic [NUM_W-1:0] num);
			pending = {pending, dixon_attempt(num)};
		endfunction

		function void check_result(factor_result_t got);
			factor_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $realtime, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status) begin
				$display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
				errors++;
			end
			if (got.divisor !== exp_r.divisor) begin
				$display("%0t: divisor exp %0d got %0d", $realtime, exp_r.divisor, got.divisor);
				errors++;
			end
			if (got.cofactor !== exp_r.cofactor) begin
				$display("%0t: cofactor exp %0d got %0d", $realtime, exp_r.cofactor,
					got.cofactor);
				errors++;
			end
			if (got.x_product !== exp_r.x_product) begin
				$display("%0t: x_product exp %0d got %0d", $realtime, exp_r.x_product,
					got.x_product);
				errors++;
			end
			if (got.y_product !== exp_r.y_product) begin
				$display("%0t: y_product exp %0d got %0d", $realtime, exp_r.y_product,
					got.y_product);
				errors++;
			end
			if (got.chosen_subset !== exp_r.chosen_subset) begin
				$display("%0t: chosen_subset exp %0d got %0d", $realtime,
					exp_r.chosen_subset, got.chosen_subset);
				errors++;
			end
			if (got.relations_found !== exp_r.relations_found) begin
				$display("%0t: relations_found exp %0d got %0d", $realtime,
					exp_r.relations_found, got.relations_found);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [NUM_W-1:0]   number = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [ST_W-1:0]    status;
	logic [NUM_W-1:0]   divisor, cofactor, x_product, y_product;
	logic [OMASK_W-1:0] chosen_subset;
	logic [REL_W-1:0]   relations_found;

	factor_scoreboard   sb = new();
	bit                 steady = 0;
	int unsigned        quiet_cycles = 0;

	dixon_factor_finder_core DUT (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result('{status, divisor, cofactor, x_product, y_product,
					chosen_subset, relations_found});
			out_ready <= steady || ($urandom_range(99) >= 23);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic send_number(logic [NUM_W-1:0] num);
		int unsigned gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 23) gap++;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		number <= num;
		do @(posedge clk); while (!in_ready);
		sb.note_number(num);
	endtask

	function automatic logic [NUM_W-1:0] pick_number();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 4) return $urandom_range(1);
		if (sel < 70) return $urandom_range(511, 2);
		if (sel < 86) return $urandom_range(4095, 512);
		if (sel < 95) return $urandom_range(16383, 4096);
		return $urandom_range(65535, 16384);
	endfunction

	initial begin
		logic [NUM_W-1:0] directed [$];
		directed = '{0, 1, 2, 3, 4, 5, 9, 15, 16, 21, 25, 49,
			77, 97, 210, 221, 1001, 4096, 32768, 65521, 65534, 65535};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) send_number(directed[i]);
		for (int i = 0; i < 78; i++) begin
			steady = (i >= 40 && i < 60);
			send_number(pick_number());
		end
		steady = 0;
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

`default_nettype wire
